/* hw/rtl/grouped_random_shuffle_unit_defines.svh */
// Assertion macros for the grouped random shuffle unit.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef GROUPED_RANDOM_SHUFFLE_UNIT_DEFINES_SVH
`define GROUPED_RANDOM_SHUFFLE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define GRSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GRSU_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GRSU_ASSERT(lbl, prop, msg)
`define GRSU_ASSERT_NR(lbl, prop, msg)
`endif
`endif

/* hw/rtl/grsu_pkg.sv */
// Package for the grouped random shuffle unit: sizes, codes, types, LFSR step.
// No dependencies.
package grsu_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned FAM_W       = 2;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned LFSR_W      = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ORD_AW      = IDX_W + 1;
  localparam int unsigned ENT_W       = ID_BITS + FAM_W;

  localparam logic [LFSR_W-1:0] LFSR_TOGGLE = 32'h8020_0003;

  localparam logic [CFG_IDX_W-1:0] REG_PREF_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd1;

  localparam logic [MODE_W-1:0] MODE_EQUAL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_V4_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_V6_FIRST = 2'd2;

  localparam logic [FAM_W-1:0] FAM_V4 = 2'd0;
  localparam logic [FAM_W-1:0] FAM_V6 = 2'd1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PART_RD,
    ST_PART_WR,
    ST_GRP,
    ST_GRP_END,
    ST_DRAW,
    ST_MOD_WAIT,
    ST_SW_RDJ,
    ST_SW_WRI,
    ST_SW_WRJ,
    ST_EMIT_RD,
    ST_EMIT_CAP
  } state_e;

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    return (s >> 1) ^ (s[0] ? LFSR_TOGGLE : '0);
  endfunction

endpackage

/* hw/rtl/grsu_if.sv */
// Channel interfaces of the grouped random shuffle unit: input, output, config.
// Depends on grsu_pkg.
interface grsu_in_if;
  logic                          valid;
  logic                          ready;
  logic [grsu_pkg::ID_BITS-1:0]  entry_id;
  logic [grsu_pkg::FAM_W-1:0]    family;
  logic                          last;
  modport source (output valid, entry_id, family, last, input ready);
  modport sink   (input valid, entry_id, family, last, output ready);
endinterface

interface grsu_out_if;
  logic                          valid;
  logic                          ready;
  logic [grsu_pkg::ID_BITS-1:0]  out_entry_id;
  logic                          out_last;
  modport source (output valid, out_entry_id, out_last, input ready);
  modport sink   (input valid, out_entry_id, out_last, output ready);
endinterface

interface grsu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [grsu_pkg::CFG_IDX_W-1:0]   index;
  logic [grsu_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/grsu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/grsu_mod.sv */
// Bit-serial remainder unit: 32-bit draw modulo a small divisor, one bit a cycle.
// Depends on grsu_pkg.
module grsu_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grsu_pkg::mod_req_t req_i,
  output grsu_pkg::mod_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(grsu_pkg::LFSR_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [StepW-1:0]              step_q, step_d;
  logic [grsu_pkg::LFSR_W-1:0]   dvd_q, dvd_d;
  logic [grsu_pkg::CNT_W-1:0]    div_q, div_d;
  logic [grsu_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [grsu_pkg::CNT_W:0]      trial;

  assign trial = {rem_q, dvd_q[grsu_pkg::LFSR_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = StepW'(grsu_pkg::LFSR_W - 1);
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = grsu_pkg::CNT_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = grsu_pkg::CNT_W'(trial);
      end
      step_d = step_q - StepW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* hw/rtl/grouped_random_shuffle_unit.sv */
// Top level of the grouped random shuffle unit: sequencer, LFSR, config.
// Depends on grsu_pkg, grsu_if, grsu_ram, grsu_mod and the defines header.
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid/ready   | entry_id, family, last
//  out_o   | out | valid/ready   | out_entry_id, out_last
//  cfg_i   | in  | valid/ready   | index (0 pref_mode, 1 seed), data
//
// Loading takes in items until a last item. The list is then split into groups,
// and each group is shuffled by swaps (one LFSR draw, a wait on the bit-serial
// remainder unit, then the four RAM accesses); after that the results are emitted.
// Reset leaves mode 0, LFSR 1 and an empty list; no clearing pass is needed.
// A stalled output holds the sequencer; the output register frees the input
// side once the final result is registered. Config is always ready.
`include "grouped_random_shuffle_unit_defines.svh"

module grouped_random_shuffle_unit (
  input logic        clk_i,
  input logic        rst_ni,
  grsu_in_if.sink    in_i,
  grsu_out_if.source out_o,
  grsu_cfg_if.sink   cfg_i
);

  localparam int unsigned SumW = grsu_pkg::CNT_W + 1;
  localparam logic [grsu_pkg::CNT_W-1:0] CntMax = grsu_pkg::CNT_W'(grsu_pkg::MAX_ENTRIES);

  grsu_pkg::state_e                state_q, state_d;
  logic [grsu_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [grsu_pkg::CNT_W-1:0]      k_q, k_d;
  logic [grsu_pkg::CNT_W-1:0]      np_q, np_d;
  logic [grsu_pkg::CNT_W-1:0]      no_q, no_d;
  logic                            grp_q, grp_d;
  logic [grsu_pkg::IDX_W-1:0]      i_q, i_d;
  logic [grsu_pkg::IDX_W-1:0]      j_q, j_d;
  logic [grsu_pkg::ID_BITS-1:0]    di_q, di_d;
  logic [grsu_pkg::MODE_W-1:0]     mode_q, mode_d;
  logic [grsu_pkg::LFSR_W-1:0]     lfsr_q, lfsr_d;
  logic                            out_valid_q, out_valid_d;
  logic [grsu_pkg::ID_BITS-1:0]    out_id_q, out_id_d;
  logic                            out_last_q, out_last_d;

  logic                            ent_we, ent_re;
  logic [grsu_pkg::IDX_W-1:0]      ent_waddr, ent_raddr;
  logic [grsu_pkg::ENT_W-1:0]      ent_wdata, ent_rdata;
  logic                            ord_we, ord_re;
  logic [grsu_pkg::ORD_AW-1:0]     ord_waddr, ord_raddr;
  logic [grsu_pkg::ID_BITS-1:0]    ord_wdata, ord_rdata;

  grsu_pkg::mod_req_t              mod_req;
  grsu_pkg::mod_rsp_t              mod_rsp;

  logic                            in_acc, out_take, cfg_acc, in_ready;
  logic [grsu_pkg::CNT_W-1:0]      grp_size;
  logic [grsu_pkg::FAM_W-1:0]      ent_fam;
  logic                            ent_pref, emit_last;
  logic [grsu_pkg::LFSR_W-1:0]     lfsr_next;

  grsu_ram #(.Width(grsu_pkg::ENT_W), .Depth(grsu_pkg::MAX_ENTRIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  grsu_ram #(.Width(grsu_pkg::ID_BITS), .Depth(2 * grsu_pkg::MAX_ENTRIES)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  grsu_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign in_acc    = in_i.valid & in_ready;
  assign out_take  = out_valid_q & out_o.ready;
  assign cfg_acc   = cfg_i.valid;
  assign grp_size  = grp_q ? no_q : np_q;
  assign ent_fam   = ent_rdata[grsu_pkg::FAM_W-1:0];
  assign lfsr_next = grsu_pkg::lfsr_step(lfsr_q);

  always_comb begin
    priority if (mode_q == grsu_pkg::MODE_V4_FIRST) begin
      ent_pref = (ent_fam == grsu_pkg::FAM_V4);
    end else if (mode_q == grsu_pkg::MODE_V6_FIRST) begin
      ent_pref = (ent_fam == grsu_pkg::FAM_V6);
    end else begin
      ent_pref = 1'b1;
    end
  end

  always_comb begin
    if (grp_q) begin
      emit_last = ((k_q + grsu_pkg::CNT_W'(1)) == no_q);
    end else begin
      emit_last = ((k_q + grsu_pkg::CNT_W'(1)) == np_q) && (no_q == '0);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    np_d        = np_q;
    no_d        = no_q;
    grp_d       = grp_q;
    i_d         = i_q;
    j_d         = j_q;
    di_d        = di_q;
    mode_d      = mode_q;
    lfsr_d      = lfsr_q;
    out_valid_d = out_valid_q & ~out_take;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    in_ready    = 1'b0;
    ent_we      = 1'b0;
    ent_waddr   = cnt_q[grsu_pkg::IDX_W-1:0];
    ent_wdata   = {in_i.entry_id, in_i.family};
    ent_re      = 1'b0;
    ent_raddr   = k_q[grsu_pkg::IDX_W-1:0];
    ord_we      = 1'b0;
    ord_waddr   = {grp_q, i_q};
    ord_wdata   = ord_rdata;
    ord_re      = 1'b0;
    ord_raddr   = {grp_q, i_q};
    mod_req.start    = 1'b0;
    mod_req.dividend = lfsr_next;
    mod_req.divisor  = grsu_pkg::CNT_W'(i_q) + grsu_pkg::CNT_W'(1);

    unique case (state_q)
      grsu_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (cnt_q < CntMax) begin
            ent_we = 1'b1;
            cnt_d  = cnt_q + grsu_pkg::CNT_W'(1);
          end
          if (in_i.last) begin
            k_d     = '0;
            np_d    = '0;
            no_d    = '0;
            state_d = grsu_pkg::ST_PART_RD;
          end
        end
      end
      grsu_pkg::ST_PART_RD: begin
        if (k_q == cnt_q) begin
          grp_d   = 1'b0;
          state_d = grsu_pkg::ST_GRP;
        end else begin
          ent_re  = 1'b1;
          state_d = grsu_pkg::ST_PART_WR;
        end
      end
      grsu_pkg::ST_PART_WR: begin
        ord_we    = 1'b1;
        ord_wdata = ent_rdata[grsu_pkg::ENT_W-1:grsu_pkg::FAM_W];
        if (ent_pref) begin
          ord_waddr = {1'b0, np_q[grsu_pkg::IDX_W-1:0]};
          np_d      = np_q + grsu_pkg::CNT_W'(1);
        end else begin
          ord_waddr = {1'b1, no_q[grsu_pkg::IDX_W-1:0]};
          no_d      = no_q + grsu_pkg::CNT_W'(1);
        end
        k_d     = k_q + grsu_pkg::CNT_W'(1);
        state_d = grsu_pkg::ST_PART_RD;
      end
      grsu_pkg::ST_GRP: begin
        if (grp_size >= grsu_pkg::CNT_W'(2)) begin
          i_d     = grsu_pkg::IDX_W'(grp_size - grsu_pkg::CNT_W'(1));
          state_d = grsu_pkg::ST_DRAW;
        end else begin
          state_d = grsu_pkg::ST_GRP_END;
        end
      end
      grsu_pkg::ST_GRP_END: begin
        if (!grp_q) begin
          grp_d   = 1'b1;
          state_d = grsu_pkg::ST_GRP;
        end else begin
          grp_d   = 1'b0;
          k_d     = '0;
          state_d = grsu_pkg::ST_EMIT_RD;
        end
      end
      grsu_pkg::ST_DRAW: begin
        lfsr_d        = lfsr_next;
        mod_req.start = 1'b1;
        state_d       = grsu_pkg::ST_MOD_WAIT;
      end
      grsu_pkg::ST_MOD_WAIT: begin
        if (mod_rsp.done) begin
          j_d     = mod_rsp.rem[grsu_pkg::IDX_W-1:0];
          ord_re  = 1'b1;
          state_d = grsu_pkg::ST_SW_RDJ;
        end
      end
      grsu_pkg::ST_SW_RDJ: begin
        di_d      = ord_rdata;
        ord_re    = 1'b1;
        ord_raddr = {grp_q, j_q};
        state_d   = grsu_pkg::ST_SW_WRI;
      end
      grsu_pkg::ST_SW_WRI: begin
        ord_we  = 1'b1;
        state_d = grsu_pkg::ST_SW_WRJ;
      end
      grsu_pkg::ST_SW_WRJ: begin
        ord_we    = 1'b1;
        ord_waddr = {grp_q, j_q};
        ord_wdata = di_q;
        if (i_q == grsu_pkg::IDX_W'(1)) begin
          state_d = grsu_pkg::ST_GRP_END;
        end else begin
          i_d     = i_q - grsu_pkg::IDX_W'(1);
          state_d = grsu_pkg::ST_DRAW;
        end
      end
      grsu_pkg::ST_EMIT_RD: begin
        if (!grp_q && (k_q == np_q)) begin
          grp_d = 1'b1;
          k_d   = '0;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = {grp_q, k_q[grsu_pkg::IDX_W-1:0]};
          state_d   = grsu_pkg::ST_EMIT_CAP;
        end
      end
      grsu_pkg::ST_EMIT_CAP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_id_d    = ord_rdata;
          out_last_d  = emit_last;
          if (emit_last) begin
            cnt_d   = '0;
            state_d = grsu_pkg::ST_LOAD;
          end else begin
            k_d     = k_q + grsu_pkg::CNT_W'(1);
            state_d = grsu_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = grsu_pkg::ST_LOAD;
      end
    endcase

    if (cfg_acc) begin
      unique case (cfg_i.index)
        grsu_pkg::REG_PREF_MODE: mode_d = cfg_i.data[grsu_pkg::MODE_W-1:0];
        grsu_pkg::REG_SEED: begin
          lfsr_d = (cfg_i.data == '0) ? grsu_pkg::LFSR_W'(1) : cfg_i.data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= grsu_pkg::ST_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      np_q        <= '0;
      no_q        <= '0;
      grp_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      mode_q      <= grsu_pkg::MODE_EQUAL;
      lfsr_q      <= grsu_pkg::LFSR_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      np_q        <= np_d;
      no_q        <= no_d;
      grp_q       <= grp_d;
      i_q         <= i_d;
      j_q         <= j_d;
      mode_q      <= mode_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    di_q       <= di_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready         = in_ready;
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.out_entry_id = out_id_q;
  assign out_o.out_last     = out_last_q;

  `GRSU_ASSERT(a_done_in_wait, mod_rsp.done |-> (state_q == grsu_pkg::ST_MOD_WAIT), "remainder done outside wait")
  `GRSU_ASSERT(a_split_count, (state_q == grsu_pkg::ST_GRP) |-> ((SumW'(np_q) + SumW'(no_q)) == SumW'(cnt_q)), "group sizes do not add up")
  `GRSU_ASSERT_NR(a_swap_range, (state_q == grsu_pkg::ST_SW_RDJ) |-> (j_q <= i_q), "swap index out of range")

endmodule

/* sim/grouped_random_shuffle_unit_tb.sv */
// Self-checking testbench for grouped_random_shuffle_unit: a clocked driver and monitor,
// a shuffle predictor with its own LFSR, and phased stimulus over modes, seeds and idling.
// Depends on grsu_pkg, grsu_if and the RTL of the unit.
module grouped_random_shuffle_unit_tb;
  import grsu_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam logic [FAM_W-1:0]  FAM_OTHER     = 2'd2;
  localparam logic [FAM_W-1:0]  FAM_UNKNOWN   = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 1200;
  localparam int STALL_LIMIT   = 10000;

  typedef struct {
    logic [ID_BITS-1:0] id;
    logic [FAM_W-1:0]   fam;
    logic               last;
  } entry_item_t;

  typedef struct {
    logic [ID_BITS-1:0] id;
    logic               last;
  } shuffled_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  grsu_in_if  in_if ();
  grsu_out_if out_if ();
  grsu_cfg_if cfg_if ();

  grouped_random_shuffle_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [MODE_W-1:0]  mode_q;
  logic [LFSR_W-1:0]  lfsr_q;
  logic [ID_BITS-1:0] entry_ids [MAX_ENTRIES];
  logic [FAM_W-1:0]   entry_fams[MAX_ENTRIES];
  int                 entry_cnt;
  logic [ID_BITS-1:0] order_buf [MAX_ENTRIES];

  entry_item_t     pending_q[$];
  shuffled_entry_t shuffled_q[$];
  entry_item_t     cur_item;

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_ticket;
  int hold_seen;
  int hold_left;
  int errors;
  int items_in;
  int lists_done;
  int results_ok;
  int quiet_cycles;

  function automatic logic [LFSR_W-1:0] next_draw();
    logic [LFSR_W-1:0] s;
    s = lfsr_q >> 1;
    if (lfsr_q[0]) s = s ^ LFSR_TOGGLE;
    lfsr_q = s;
    return s;
  endfunction

  function automatic void permute_span(input int base, input int n);
    int i;
    int j;
    logic [ID_BITS-1:0] t;
    if (n < 2) return;
    for (i = n - 1; i > 0; i--) begin
      j = int'(next_draw() % 32'(i + 1));
      t = order_buf[base + i];
      order_buf[base + i] = order_buf[base + j];
      order_buf[base + j] = t;
    end
  endfunction

  function automatic void take_entry(input entry_item_t it);
    int k;
    int np;
    int n;
    logic [FAM_W-1:0] want;
    shuffled_entry_t r;
    if (entry_cnt < MAX_ENTRIES) begin
      entry_ids[entry_cnt]  = it.id;
      entry_fams[entry_cnt] = it.fam;
      entry_cnt++;
    end
    if (!it.last) return;
    n = entry_cnt;
    np = 0;
    if (mode_q == MODE_V4_FIRST || mode_q == MODE_V6_FIRST) begin
      want = (mode_q == MODE_V4_FIRST) ? FAM_V4 : FAM_V6;
      for (k = 0; k < n; k++)
        if (entry_fams[k] == want) order_buf[np++] = entry_ids[k];
      begin
        int m;
        m = np;
        for (k = 0; k < n; k++)
          if (entry_fams[k] != want) order_buf[m++] = entry_ids[k];
      end
      if (n >= 2) begin
        permute_span(0, np);
        permute_span(np, n - np);
      end
    end else begin
      for (k = 0; k < n; k++) order_buf[k] = entry_ids[k];
      permute_span(0, n);
    end
    for (k = 0; k < n; k++) begin
      r.id   = order_buf[k];
      r.last = (k + 1 == n);
      shuffled_q.push_back(r);
    end
    entry_cnt = 0;
    lists_done++;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        take_entry(cur_item);
        items_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_item = pending_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.entry_id <= cur_item.id;
          in_if.family   <= cur_item.fam;
          in_if.last     <= cur_item.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and ready generator
  always @(posedge clk_i or negedge rst_ni) begin
    shuffled_entry_t exp_e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (shuffled_q.size() == 0) begin
          $error("unexpected item: out_entry_id %h out_last %b",
                 out_if.out_entry_id, out_if.out_last);
          errors++;
        end else begin
          exp_e = shuffled_q.pop_front();
          if (out_if.out_entry_id !== exp_e.id) begin
            $error("out_entry_id: expected %h, got %h", exp_e.id, out_if.out_entry_id);
            errors++;
          end
          if (out_if.out_last !== exp_e.last) begin
            $error("out_last: expected %b, got %b", exp_e.last, out_if.out_last);
            errors++;
          end
          results_ok++;
        end
      end
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("grouped_random_shuffle_unit_tb failed");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [ID_BITS-1:0] id, input logic [FAM_W-1:0] fam,
                            input logic last);
    entry_item_t it;
    it.id   = id;
    it.fam  = fam;
    it.last = last;
    pending_q.push_back(it);
  endtask

  task automatic queue_random_list();
    int len;
    int sel;
    int k;
    sel = $urandom_range(99);
    if (sel < 70)      len = $urandom_range(6, 1);
    else if (sel < 85) len = $urandom_range(15, 7);
    else if (sel < 95) len = MAX_ENTRIES;
    else               len = $urandom_range(MAX_ENTRIES + 4, MAX_ENTRIES + 1);
    for (k = 0; k < len; k++)
      queue_item(ID_BITS'($urandom()), FAM_W'($urandom_range(3)), k == len - 1);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (!(pending_q.size() == 0 && !in_if.valid && shuffled_q.size() == 0));
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    if (idx == REG_PREF_MODE) mode_q = val[MODE_W-1:0];
    else if (idx == REG_SEED) lfsr_q = (val == '0) ? LFSR_W'(1) : val;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [CFG_DATA_W-1:0] seed,
                           input int tx_pct, input int rx_pct, input int n_items,
                           input bit long_hold);
    int start;
    drain();
    write_reg(REG_PREF_MODE, (CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(3)) | CFG_DATA_W'(mode));
    write_reg(REG_SEED, seed);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (long_hold) hold_ticket++;
    start = pending_q.size();
    while (pending_q.size() - start < n_items) queue_random_list();
  endtask

  initial begin
    int k;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.entry_id  = '0;
    in_if.family    = '0;
    in_if.last      = 1'b0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_PREF_MODE;
    cfg_if.data     = '0;
    mode_q          = MODE_EQUAL;
    lfsr_q          = LFSR_W'(1);
    entry_cnt       = 0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    hold_ticket     = 0;
    hold_seen       = 0;
    hold_left       = 0;
    errors          = 0;
    items_in        = 0;
    lists_done      = 0;
    results_ok      = 0;
    quiet_cycles    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset configuration: single entry, extremes, overflow with dropped last
    queue_item(16'hFFFF, FAM_UNKNOWN, 1'b1);
    queue_item(16'h0000, FAM_V4, 1'b0);
    queue_item(16'hFFFF, FAM_V6, 1'b0);
    queue_item(16'hA5A5, FAM_OTHER, 1'b1);
    for (k = 0; k < MAX_ENTRIES; k++)
      queue_item(ID_BITS'(16'h1000 + k * 16'h0111), FAM_W'(k % 4), 1'b0);
    queue_item(16'hBEEF, FAM_V4, 1'b1);
    drain();
    // preferred group of one, others of three
    write_reg(REG_PREF_MODE, CFG_DATA_W'(MODE_V4_FIRST));
    queue_item(16'h0001, FAM_V4, 1'b0);
    queue_item(16'h0002, FAM_V6, 1'b0);
    queue_item(16'h0003, FAM_UNKNOWN, 1'b0);
    queue_item(16'h0004, FAM_OTHER, 1'b1);

    run_phase(MODE_EQUAL, 32'hFFFF_FFFF, 0, 0, 70, 1'b0);
    run_phase(MODE_V4_FIRST, 32'h0000_0000, 68, 0, 65, 1'b0);
    run_phase(MODE_V6_FIRST, 32'h8000_0000, 0, 68, 65, 1'b1);
    run_phase(MODE_RESERVED, 32'($urandom()), 14, 14, 65, 1'b0);
    run_phase(MODE_V6_FIRST, 32'($urandom()), 68, 0, 60, 1'b0);
    run_phase(MODE_EQUAL, 32'h0000_0001, 0, 0, 50, 1'b0);
    drain();
    repeat (100) @(posedge clk_i);

    $display("run covered %0d items in %0d lists, %0d shuffled entries checked,",
             items_in, lists_done, results_ok);
    $display("all four mode codes, zero and all-ones seeds, overflow and idle/stall phases");
    if (errors == 0 && shuffled_q.size() == 0) begin
      $display("grouped_random_shuffle_unit_tb passed");
    end else begin
      $display("grouped_random_shuffle_unit_tb failed");
    end
    $finish;
  end

endmodule

/* grouped_random_shuffle_unit.f */
+incdir+hw/rtl
hw/rtl/grsu_pkg.sv
hw/rtl/grsu_if.sv
hw/rtl/grsu_ram.sv
hw/rtl/grsu_mod.sv
hw/rtl/grouped_random_shuffle_unit.sv
sim/grouped_random_shuffle_unit_tb.sv
